// ===== rtl/core/npdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// npdcm_pkg
// Shared types, sizes and codes of the nearest-point deviation color map.
// ----------------------------------------------------------------------------
`default_nettype none

package npdcm_pkg;

    localparam int REF_POINTS   = 1024;
    localparam int QUERY_POINTS = 1024;
    localparam int COORD_WIDTH  = 24;
    localparam int DIST_W       = 52;

    localparam int REF_IDX_W = $clog2(REF_POINTS);
    localparam int REF_CNT_W = $clog2(REF_POINTS + 1);
    localparam int Q_IDX_W   = $clog2(QUERY_POINTS);
    localparam int Q_CNT_W   = $clog2(QUERY_POINTS + 1);
    localparam int READ_IDX_W = 10;

    localparam int PT_W  = 3 * COORD_WIDTH;
    localparam int QRY_W = PT_W + DIST_W;

    localparam int S_TDATA_W = ((2 + PT_W + READ_IDX_W + 7) / 8) * 8;
    localparam int M_RAW_W   = PT_W + DIST_W + 24 + 2;
    localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;

    localparam logic [DIST_W-1:0] DIST_MAX  = '1;
    localparam logic [DIST_W-1:0] THR_RESET = DIST_W'(524);

    localparam int APB_ADDR_W = 4;
    localparam logic [APB_ADDR_W-1:0] ADDR_NEAR_THR = '0;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SEARCH = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_NO_REF    = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    // band 0 is the near match, 1..5 the deviation bands
    function automatic color_t band_color(input logic [2:0] band);
        color_t c;
        unique case (band)
            3'd0:    c = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
            3'd1:    c = '{blue: 8'd239, green: 8'd192, red: 8'd23};
            3'd2:    c = '{blue: 8'd242, green: 8'd144, red: 8'd30};
            3'd3:    c = '{blue: 8'd236, green: 8'd112, red: 8'd30};
            3'd4:    c = '{blue: 8'd246, green: 8'd80,  red: 8'd30};
            default: c = '{blue: 8'd255, green: 8'd50,  red: 8'd30};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/npdcm_ram.sv =====
// ----------------------------------------------------------------------------
// npdcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module npdcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/npdcm_dist.sv =====
// ----------------------------------------------------------------------------
// npdcm_dist
// Pipelined squared-distance unit; scans all references, keeps the minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module npdcm_dist import npdcm_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [PT_W-1:0]        query,
    input  wire logic [REF_CNT_W-1:0]   ref_count,
    output logic                        rd_en,
    output logic      [REF_IDX_W-1:0]   rd_addr,
    input  wire logic [PT_W-1:0]        rd_data,
    output logic                        done,
    output logic      [DIST_W-1:0]      best
);

    localparam int W = COORD_WIDTH;

    logic                   busy_reg, busy_next;
    logic                   issue_reg, issue_next;
    logic [REF_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [REF_CNT_W-1:0]   n_reg;
    logic [PT_W-1:0]        q_reg;
    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic [W-1:0]           ad_reg [3];
    logic [2*W-1:0]         sq_reg [3];
    logic [DIST_W-1:0]      sum_reg;
    logic [DIST_W-1:0]      best_reg;
    logic [W:0]             diff [3];
    logic                   done_reg;

    assign rd_en   = issue_reg;
    assign rd_addr = cnt_reg[REF_IDX_W-1:0];
    assign done    = done_reg;
    assign best    = best_reg;

    always_comb begin
        busy_next  = busy_reg;
        issue_next = issue_reg;
        cnt_next   = cnt_reg;
        if (start) begin
            busy_next  = 1'b1;
            issue_next = 1'b1;
            cnt_next   = '0;
        end else if (issue_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg + 1'b1 == n_reg) begin
                issue_next = 1'b0;
            end
        end else if (busy_reg && !v1_reg && !v2_reg && !v3_reg && !v4_reg) begin
            busy_next = 1'b0;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = {q_reg[k*W+W-1], q_reg[k*W +: W]}
                    - {rd_data[k*W+W-1], rd_data[k*W +: W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            issue_reg <= 1'b0;
            cnt_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            issue_reg <= issue_next;
            cnt_reg   <= cnt_next;
            v1_reg    <= issue_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            done_reg  <= busy_reg && !busy_next;
        end
    end

    // |diff| fits W bits; sum of three squares stays below 2^52 for W = 24
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg    <= query;
            n_reg    <= ref_count;
            best_reg <= DIST_MAX;
        end
        for (int k = 0; k < 3; k++) begin
            ad_reg[k] <= diff[k][W] ? W'(-diff[k]) : diff[k][W-1:0];
            sq_reg[k] <= ad_reg[k] * ad_reg[k];
        end
        sum_reg <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
        if (v4_reg && sum_reg < best_reg) begin
            best_reg <= sum_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/npdcm_color.sv =====
// ----------------------------------------------------------------------------
// npdcm_color
// Deviation color: near match at or below thr, else span times one fifth by a
// shared 26x26 multiplier over four steps, then band search.
// ----------------------------------------------------------------------------
`default_nettype none

module npdcm_color import npdcm_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIST_W-1:0] sq_dist,
    input  wire logic [DIST_W-1:0] thr,
    input  wire logic [DIST_W-1:0] max_d,
    input  wire logic [DIST_W-1:0] min_d,
    output logic                   done,
    output color_t                 color
);

    localparam int HALF      = DIST_W / 2;
    localparam int PROD_W    = 2 * DIST_W;
    localparam int QUO_SHIFT = DIST_W + 2;
    // floor(x / 5) == (x * ceil(2^54 / 5)) >> 54 for every x below 2^52
    localparam logic [DIST_W-1:0] RECIP5 = DIST_W'(64'h000C_CCCC_CCCC_CCCD);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_MUL  = 3'b010,
        C_BAND = 3'b100
    } cstate_t;

    cstate_t            state_reg, state_next;
    logic [DIST_W-1:0]  d_reg, d_next;
    logic [DIST_W-1:0]  span_reg, span_next;
    logic [DIST_W-1:0]  quo_reg, quo_next;
    logic [1:0]         step_reg, step_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [DIST_W:0]    acc_reg, acc_next;
    logic [2:0]         band_reg, band_next;
    logic               done_reg, done_next;
    color_t             col_reg, col_next;
    logic [HALF-1:0]    mul_a;
    logic [HALF-1:0]    mul_b;
    logic [2*HALF-1:0]  pp;
    logic [PROD_W-1:0]  pp_sh;

    assign done  = done_reg;
    assign color = col_reg;

    always_comb begin
        mul_a = step_reg[0] ? span_reg[DIST_W-1:HALF] : span_reg[HALF-1:0];
        mul_b = step_reg[1] ? RECIP5[DIST_W-1:HALF] : RECIP5[HALF-1:0];
        pp    = mul_a * mul_b;
        unique case (step_reg)
            2'd0:       pp_sh = PROD_W'(pp);
            2'd1, 2'd2: pp_sh = PROD_W'(pp) << HALF;
            2'd3:       pp_sh = PROD_W'(pp) << (2 * HALF);
        endcase
    end

    always_comb begin
        state_next = state_reg;
        d_next     = d_reg;
        span_next  = span_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        band_next  = band_reg;
        done_next  = 1'b0;
        col_next   = col_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (start) begin
                    d_next = sq_dist;
                    if (sq_dist <= thr) begin
                        col_next  = band_color(3'd0);
                        done_next = 1'b1;
                    end else begin
                        span_next  = (max_d >= min_d) ? max_d - min_d : '0;
                        prod_next  = '0;
                        step_next  = '0;
                        state_next = C_MUL;
                    end
                end
            end
            C_MUL: begin
                prod_next = prod_reg + pp_sh;
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd3) begin
                    quo_next   = DIST_W'(prod_next[PROD_W-1:QUO_SHIFT]);
                    acc_next   = {1'b0, quo_next};
                    band_next  = 3'd1;
                    state_next = C_BAND;
                end
            end
            C_BAND: begin
                if ({1'b0, d_reg} <= acc_reg) begin
                    col_next   = band_color(band_reg);
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end else if (band_reg == 3'd4) begin
                    col_next   = band_color(3'd5);
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end else begin
                    acc_next  = acc_reg + {1'b0, quo_reg};
                    band_next = band_reg + 1'b1;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg    <= d_next;
        span_reg <= span_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        band_reg <= band_next;
        col_reg  <= col_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/nearest_point_deviation_color_map.sv =====
// ----------------------------------------------------------------------------
// nearest_point_deviation_color_map
// Exhaustive nearest-reference search with a deviation color readout.
// ----------------------------------------------------------------------------
// Load and clear are taken in the idle state and s_tready stays high, except
// for a load into a full store, which returns an error item. A search item
// goes one reference per cycle through the distance pipeline, then a 4-step
// multiply by one fifth and up to four band compares. Error items go straight
// to the output. One item at a time; s_tready returns as m_tvalid rises.
// Reset (aresetn low, synchronous) zeroes both counts, restores min/max and
// near_threshold; store contents are kept.
`default_nettype none

module nearest_point_deviation_color_map import npdcm_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // operation, x_coord, y_coord, z_coord, read_index
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_x, out_y, out_z, sq_distance, red, green, blue, status
    output logic      [M_TDATA_W-1:0]  m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [63:0]           pwdata,
    output logic      [63:0]           prdata,
    output logic                       pready
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_RDW   = 5'b00100,
        ST_COLOR = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [REF_CNT_W-1:0] rcnt_reg, rcnt_next;
    logic [Q_CNT_W-1:0]  qcnt_reg, qcnt_next;
    logic [DIST_W-1:0]   max_reg, max_next;
    logic [DIST_W-1:0]   min_reg, min_next;
    logic [DIST_W-1:0]   thr_reg;
    logic                col_go_reg, col_go_next;
    logic                mv_reg;
    logic [M_TDATA_W-1:0] md_reg;

    logic [PT_W-1:0]     pay_pt_reg, pay_pt_next;
    logic [DIST_W-1:0]   pay_d_reg, pay_d_next;
    color_t              pay_col_reg, pay_col_next;
    status_t             pay_st_reg, pay_st_next;

    op_t                 in_op;
    logic [PT_W-1:0]     in_pt;
    logic [READ_IDX_W-1:0] in_idx;
    logic                acc;

    logic                ref_we;
    logic                dist_rd_en, dist_done;
    logic [REF_IDX_W-1:0] dist_rd_addr;
    logic [PT_W-1:0]     ref_rdata;
    logic [DIST_W-1:0]   dist_best;
    logic                q_we, q_re;
    logic [QRY_W-1:0]    q_rdata;
    logic                col_done;
    color_t              col_out;
    logic                out_free;
    logic                cfg_wr;

    assign in_op  = op_t'(s_tdata[1:0]);
    assign in_pt  = s_tdata[2 +: PT_W];
    assign in_idx = s_tdata[2 + PT_W +: READ_IDX_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign acc    = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;

    assign ref_we = acc && in_op == OP_LOAD && rcnt_reg < REF_CNT_W'(REF_POINTS);
    assign q_we   = state_reg == ST_SCAN && dist_done;
    assign q_re   = acc && in_op == OP_READ;

    npdcm_ram #(.WIDTH(PT_W), .DEPTH(REF_POINTS)) u_ref_ram (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (rcnt_reg[REF_IDX_W-1:0]),
        .wdata (in_pt),
        .re    (dist_rd_en),
        .raddr (dist_rd_addr),
        .rdata (ref_rdata)
    );

    npdcm_ram #(.WIDTH(QRY_W), .DEPTH(QUERY_POINTS)) u_qry_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (qcnt_reg[Q_IDX_W-1:0]),
        .wdata ({dist_best, pay_pt_reg}),
        .re    (q_re),
        .raddr (Q_IDX_W'(in_idx)),
        .rdata (q_rdata)
    );

    npdcm_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (acc && in_op == OP_SEARCH && state_next == ST_SCAN),
        .query     (in_pt),
        .ref_count (rcnt_reg),
        .rd_en     (dist_rd_en),
        .rd_addr   (dist_rd_addr),
        .rd_data   (ref_rdata),
        .done      (dist_done),
        .best      (dist_best)
    );

    npdcm_color u_color (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (col_go_reg),
        .sq_dist (pay_d_reg),
        .thr     (thr_reg),
        .max_d   (max_reg),
        .min_d   (min_reg),
        .done    (col_done),
        .color   (col_out)
    );

    always_comb begin
        state_next   = state_reg;
        rcnt_next    = rcnt_reg;
        qcnt_next    = qcnt_reg;
        max_next     = max_reg;
        min_next     = min_reg;
        col_go_next  = 1'b0;
        pay_pt_next  = pay_pt_reg;
        pay_d_next   = pay_d_reg;
        pay_col_next = pay_col_reg;
        pay_st_next  = pay_st_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    pay_pt_next  = '0;
                    pay_d_next   = '0;
                    pay_col_next = '0;
                    unique case (in_op)
                        OP_LOAD: begin
                            if (ref_we) begin
                                rcnt_next = rcnt_reg + 1'b1;
                            end else begin
                                pay_st_next = ST_FULL;
                                state_next  = ST_OUT;
                            end
                        end
                        OP_SEARCH: begin
                            if (rcnt_reg == '0) begin
                                pay_st_next = ST_NO_REF;
                                state_next  = ST_OUT;
                            end else if (qcnt_reg >= Q_CNT_W'(QUERY_POINTS)) begin
                                pay_st_next = ST_FULL;
                                state_next  = ST_OUT;
                            end else begin
                                pay_pt_next = in_pt;
                                pay_st_next = ST_OK;
                                state_next  = ST_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (Q_CNT_W'(in_idx) >= qcnt_reg) begin
                                pay_st_next = ST_BAD_INDEX;
                                state_next  = ST_OUT;
                            end else begin
                                pay_st_next = ST_OK;
                                state_next  = ST_RDW;
                            end
                        end
                        default: begin
                            rcnt_next = '0;
                            qcnt_next = '0;
                            max_next  = '0;
                            min_next  = DIST_MAX;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (dist_done) begin
                    pay_d_next  = dist_best;
                    qcnt_next   = qcnt_reg + 1'b1;
                    max_next    = (dist_best > max_reg) ? dist_best : max_reg;
                    min_next    = (dist_best < min_reg) ? dist_best : min_reg;
                    col_go_next = 1'b1;
                    state_next  = ST_COLOR;
                end
            end
            ST_RDW: begin
                pay_pt_next = q_rdata[PT_W-1:0];
                pay_d_next  = q_rdata[QRY_W-1:PT_W];
                col_go_next = 1'b1;
                state_next  = ST_COLOR;
            end
            ST_COLOR: begin
                if (col_done) begin
                    pay_col_next = col_out;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rcnt_reg   <= '0;
            qcnt_reg   <= '0;
            max_reg    <= '0;
            min_reg    <= DIST_MAX;
            thr_reg    <= THR_RESET;
            col_go_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rcnt_reg   <= rcnt_next;
            qcnt_reg   <= qcnt_next;
            max_reg    <= max_next;
            min_reg    <= min_next;
            col_go_reg <= col_go_next;
            if (cfg_wr && paddr == ADDR_NEAR_THR) begin
                thr_reg <= pwdata[DIST_W-1:0];
            end
            if (state_reg == ST_OUT && out_free) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pay_pt_reg  <= pay_pt_next;
        pay_d_reg   <= pay_d_next;
        pay_col_reg <= pay_col_next;
        pay_st_reg  <= pay_st_next;
        if (state_reg == ST_OUT && out_free) begin
            md_reg <= M_TDATA_W'({pay_st_reg, pay_col_reg.blue, pay_col_reg.green,
                                  pay_col_reg.red, pay_d_reg, pay_pt_reg});
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_NEAR_THR) ? 64'(thr_reg) : '0;

    a_ref_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= REF_CNT_W'(REF_POINTS))
        else $error("reference count beyond store depth");

    a_qry_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qcnt_reg <= Q_CNT_W'(QUERY_POINTS))
        else $error("query count beyond store depth");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && pay_st_reg != ST_OK) |->
            (pay_d_reg == '0 && pay_pt_reg == '0 && pay_col_reg == '0))
        else $error("error item carries nonzero fields");

    a_scan_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && dist_done) |=> state_reg == ST_COLOR && col_go_reg)
        else $error("search did not move on to coloring");

endmodule

`default_nettype wire

// ===== verif/npdcm_checker.sv =====
// ----------------------------------------------------------------------------
// npdcm_checker
// Watches the item, result and register ports of the deviation color map,
// predicts every result from an exhaustive nearest-reference search and
// compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module npdcm_checker import npdcm_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [63:0]           pwdata,
    input  wire logic                  pready,
    output int                         fails,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [23:0]       x;
        logic [23:0]       y;
        logic [23:0]       z;
        logic [DIST_W-1:0] sq_dist;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        status_t           status;
    } pixel_t;

    logic [23:0]       ref_x [REF_POINTS];
    logic [23:0]       ref_y [REF_POINTS];
    logic [23:0]       ref_z [REF_POINTS];
    logic [23:0]       qry_x [QUERY_POINTS];
    logic [23:0]       qry_y [QUERY_POINTS];
    logic [23:0]       qry_z [QUERY_POINTS];
    logic [DIST_W-1:0] qry_dist [QUERY_POINTS];
    int                n_refs;
    int                n_queries;
    logic [DIST_W-1:0] dist_hi;
    logic [DIST_W-1:0] dist_lo;
    logic [DIST_W-1:0] near_thr;
    pixel_t            expected_pixels[$];
    int                n_mismatch;

    assign fails   = n_mismatch;
    assign pending = expected_pixels.size();

    function automatic logic [63:0] sq_gap(logic [23:0] a, logic [23:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        return 64'(d * d);
    endfunction

    function automatic pixel_t error_pixel(status_t st);
        pixel_t p;
        p = '{x: '0, y: '0, z: '0, sq_dist: '0, red: '0, green: '0, blue: '0,
              status: st};
        return p;
    endfunction

    function automatic pixel_t colored_pixel(int i);
        pixel_t            p;
        logic [DIST_W-1:0] d;
        logic [63:0]       span;
        logic [63:0]       step;
        d = qry_dist[i];
        p.x = qry_x[i];
        p.y = qry_y[i];
        p.z = qry_z[i];
        p.sq_dist = d;
        p.status = ST_OK;
        span = (dist_hi >= dist_lo) ? 64'(dist_hi - dist_lo) : 64'd0;
        step = span / 5;
        if (d <= near_thr)        {p.red, p.green, p.blue} = {8'd0,  8'd255, 8'd0};
        else if (d <= step)       {p.red, p.green, p.blue} = {8'd23, 8'd192, 8'd239};
        else if (d <= 2 * step)   {p.red, p.green, p.blue} = {8'd30, 8'd144, 8'd242};
        else if (d <= 3 * step)   {p.red, p.green, p.blue} = {8'd30, 8'd112, 8'd236};
        else if (d <= 4 * step)   {p.red, p.green, p.blue} = {8'd30, 8'd80,  8'd246};
        else                      {p.red, p.green, p.blue} = {8'd30, 8'd50,  8'd255};
        return p;
    endfunction

    task automatic queue_pixel(pixel_t p);
        expected_pixels = {expected_pixels, p};
    endtask

    task automatic apply_item(logic [S_TDATA_W-1:0] item);
        op_t               op;
        logic [23:0]       x;
        logic [23:0]       y;
        logic [23:0]       z;
        int                idx;
        logic [63:0]       d;
        logic [DIST_W-1:0] best;
        op  = op_t'(item[1:0]);
        x   = item[25:2];
        y   = item[49:26];
        z   = item[73:50];
        idx = int'(item[83:74]);
        case (op)
            OP_LOAD: begin
                if (n_refs >= REF_POINTS) begin
                    queue_pixel(error_pixel(ST_FULL));
                end else begin
                    ref_x[n_refs] = x;
                    ref_y[n_refs] = y;
                    ref_z[n_refs] = z;
                    n_refs++;
                end
            end
            OP_SEARCH: begin
                if (n_refs == 0) begin
                    queue_pixel(error_pixel(ST_NO_REF));
                end else if (n_queries >= QUERY_POINTS) begin
                    queue_pixel(error_pixel(ST_FULL));
                end else begin
                    best = DIST_MAX;
                    for (int i = 0; i < n_refs; i++) begin
                        d = sq_gap(x, ref_x[i]) + sq_gap(y, ref_y[i]) + sq_gap(z, ref_z[i]);
                        if (d > 64'(DIST_MAX)) d = 64'(DIST_MAX);
                        if (d < 64'(best)) best = DIST_W'(d);
                    end
                    qry_x[n_queries] = x;
                    qry_y[n_queries] = y;
                    qry_z[n_queries] = z;
                    qry_dist[n_queries] = best;
                    if (best > dist_hi) dist_hi = best;
                    if (best < dist_lo) dist_lo = best;
                    queue_pixel(colored_pixel(n_queries));
                    n_queries++;
                end
            end
            OP_READ: begin
                if (idx >= n_queries) queue_pixel(error_pixel(ST_BAD_INDEX));
                else queue_pixel(colored_pixel(idx));
            end
            default: begin
                n_refs = 0;
                n_queries = 0;
                dist_hi = '0;
                dist_lo = DIST_MAX;
            end
        endcase
    endtask

    task automatic check_pixel(logic [M_TDATA_W-1:0] word);
        pixel_t got;
        pixel_t want;
        got.x       = word[23:0];
        got.y       = word[47:24];
        got.z       = word[71:48];
        got.sq_dist = word[123:72];
        got.red     = word[131:124];
        got.green   = word[139:132];
        got.blue    = word[147:140];
        got.status  = status_t'(word[149:148]);
        if (expected_pixels.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected result item %h", word);
            return;
        end
        want = expected_pixels.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z
                || got.sq_dist !== want.sq_dist || got.red !== want.red
                || got.green !== want.green || got.blue !== want.blue
                || got.status !== want.status) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
                $display("mismatch: expected x=%h y=%h z=%h d=%h rgb=%0d,%0d,%0d st=%0d",
                         want.x, want.y, want.z, want.sq_dist, want.red, want.green,
                         want.blue, want.status);
                $display("          actual   x=%h y=%h z=%h d=%h rgb=%0d,%0d,%0d st=%0d",
                         got.x, got.y, got.z, got.sq_dist, got.red, got.green,
                         got.blue, got.status);
            end
        end
    endtask

    initial n_mismatch = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            n_refs = 0;
            n_queries = 0;
            dist_hi = '0;
            dist_lo = DIST_MAX;
            near_thr = THR_RESET;
            expected_pixels.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_NEAR_THR)
                near_thr = pwdata[DIST_W-1:0];
            if (m_tvalid && m_tready) check_pixel(m_tdata);
            if (s_tvalid && s_tready) apply_item(s_tdata);
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_nearest_point_deviation_color_map.sv =====
// ----------------------------------------------------------------------------
// tb_nearest_point_deviation_color_map
// Drives directed and random load, search, read and clear items with random
// idling on both channels and rewrites the near threshold between phases;
// the checker judges every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_nearest_point_deviation_color_map import npdcm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 3000000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // operation, x_coord, y_coord, z_coord, read_index
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // out_x, out_y, out_z, sq_distance, red, green, blue, status
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [63:0]           pwdata;
    logic [63:0]           prdata;
    logic                  pready;
    int                    fails;
    int                    pending;
    bit                    idling_on;
    longint                cycles;

    nearest_point_deviation_color_map uut (.*);

    npdcm_checker u_checker (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
        .m_tdata, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fails, .pending
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_nearest_point_deviation_color_map failed");
            $finish;
        end
    end

    // result-side stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(0, 6))
            0:       return 24'h800000;
            1:       return 24'h7fffff;
            2:       return 24'h000000;
            3:       return 24'($urandom);
            default: return 24'($signed(25'($urandom_range(0, 1 << $urandom_range(0, 22))))
                            * ($urandom_range(0, 1) ? 1 : -1));
        endcase
    endfunction

    task automatic send_point(op_t op, logic [23:0] x, logic [23:0] y, logic [23:0] z,
                              logic [9:0] idx);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, idx, z, y, x, op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_random(op_t op);
        send_point(op, pick_coord(), pick_coord(), pick_coord(),
                   $urandom_range(0, 7) == 0 ? 10'($urandom) : 10'($urandom_range(0, 20)));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_threshold(logic [63:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NEAR_THR;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_phase(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 20)      send_random(OP_LOAD);
            else if (k < 65) send_random(OP_SEARCH);
            else if (k < 96) send_random(OP_READ);
            else             send_random(OP_CLEAR);
        end
    endtask

    initial begin
        idling_on = 1'b1;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed
        send_point(OP_SEARCH, 24'h000001, 24'h000002, 24'h000003, 10'd0);
        send_point(OP_READ, '0, '0, '0, 10'd0);
        send_point(OP_READ, '0, '0, '0, 10'd1023);
        send_point(OP_LOAD, 24'h800000, 24'h800000, 24'h800000, 10'd0);
        send_point(OP_LOAD, 24'h000000, 24'h000000, 24'h000000, 10'd0);
        send_point(OP_SEARCH, 24'h7fffff, 24'h7fffff, 24'h7fffff, 10'd0);
        send_point(OP_SEARCH, 24'h000000, 24'h000000, 24'h000000, 10'd0);
        send_point(OP_SEARCH, 24'h000000, 24'h000000, 24'h000016, 10'd0);
        send_point(OP_SEARCH, 24'h000000, 24'h000000, 24'h000017, 10'd0);
        send_point(OP_SEARCH, 24'h800000, 24'h800001, 24'h800000, 10'd0);
        send_point(OP_SEARCH, 24'h001000, 24'hfff000, 24'h040000, 10'd0);
        send_point(OP_READ, '0, '0, '0, 10'd0);
        send_point(OP_READ, '0, '0, '0, 10'd5);
        send_point(OP_READ, '0, '0, '0, 10'd6);
        send_point(OP_CLEAR, '0, '0, '0, 10'd0);
        send_point(OP_READ, '0, '0, '0, 10'd0);
        send_point(OP_SEARCH, 24'h123456, 24'h654321, 24'habcdef, 10'd0);
        settle();

        write_threshold(64'd0);
        random_phase(130);
        settle();
        write_threshold(64'h000f_ffff_ffff_ffff);
        random_phase(130);
        settle();
        write_threshold(64'($urandom_range(0, 1 << 20)));
        random_phase(130);
        settle();
        write_threshold({$urandom, $urandom});
        random_phase(130);
        settle();
        write_threshold(64'd524);

        // back to back, no idling from here on
        idling_on = 1'b0;
        send_point(OP_CLEAR, '0, '0, '0, 10'd0);
        send_random(OP_LOAD);
        for (int i = 0; i < 20; i++) send_random(OP_SEARCH);
        send_point(OP_READ, '0, '0, '0, 10'd1023);
        for (int i = 0; i < 10; i++) send_point(OP_READ, '0, '0, '0, 10'($urandom));
        settle();

        if (fails == 0) begin
            $display("tb_nearest_point_deviation_color_map passed");
        end else begin
            $display("tb_nearest_point_deviation_color_map failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/npdcm_pkg.sv
rtl/core/npdcm_ram.sv
rtl/core/npdcm_dist.sv
rtl/core/npdcm_color.sv
rtl/core/nearest_point_deviation_color_map.sv
verif/npdcm_checker.sv
verif/tb_nearest_point_deviation_color_map.sv
